@@ rtl/dsp_pkg.sv @@
// ----------------------------------------------------------------------------
// dsp_pkg
// shared widths, status codes and the token passed down the parse pipeline
// ----------------------------------------------------------------------------
package dsp_pkg;

   localparam int AMT_W  = 63;               // magnitude of an amount or a total
   localparam int UNIT_W = 35;               // widest unit in milliseconds
   localparam int PROD_W = AMT_W + UNIT_W;   // full amount times unit product

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_UNIT      = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   typedef struct packed {
      logic       term;    // a finished term travels with this token
      logic       last;    // final byte of the text
      logic       neg;     // minus sign seen
      logic [1:0] fault;   // first parse error so far
   } token_type;

endpackage

@@ rtl/dsp_parse.sv @@
// ----------------------------------------------------------------------------
// dsp_parse
// byte parser: phase tracking, digit accumulation, unit recognition
// ----------------------------------------------------------------------------
module dsp_parse import dsp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [7:0]        char_in,
   input  logic              last,
   output token_type         tok_o,
   output logic [AMT_W-1:0]  amount_o,
   output logic [UNIT_W-1:0] unit_o
);

   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_SIGN   = 3'd1;
   localparam logic [2:0] PH_DONE   = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_GAP    = 3'd4;
   localparam logic [2:0] PH_UNIT   = 3'd5;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_M     = 8'h6D;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_Y     = 8'h79;

   localparam logic [UNIT_W-1:0] MS_YEAR  = 35'd31556952000;
   localparam logic [UNIT_W-1:0] MS_MONTH = 35'd2629746000;
   localparam logic [UNIT_W-1:0] MS_WEEK  = 35'd604800000;
   localparam logic [UNIT_W-1:0] MS_DAY   = 35'd86400000;
   localparam logic [UNIT_W-1:0] MS_HOUR  = 35'd3600000;
   localparam logic [UNIT_W-1:0] MS_MIN   = 35'd60000;
   localparam logic [UNIT_W-1:0] MS_SEC   = 35'd1000;
   localparam logic [UNIT_W-1:0] MS_MSEC  = 35'd1;

   // zero means no such unit
   function automatic logic [UNIT_W-1:0] unit_value(input logic [2:0][7:0] ch,
                                                    input logic [1:0] len);
      logic [UNIT_W-1:0] v;
      v = '0;
      unique case (len)
         2'd1: begin
            unique case (ch[0])
               CH_Y:    v = MS_YEAR;
               CH_W:    v = MS_WEEK;
               CH_D:    v = MS_DAY;
               CH_H:    v = MS_HOUR;
               CH_M:    v = MS_MIN;
               CH_S:    v = MS_SEC;
               default: v = '0;
            endcase
         end
         2'd2: begin
            if (ch[0] == CH_M && ch[1] == CH_S) v = MS_MSEC;
         end
         2'd3: begin
            if (ch[0] == CH_M && ch[1] == CH_O && ch[2] == CH_N) v = MS_MONTH;
         end
         default: v = '0;
      endcase
      return v;
   endfunction

   logic [2:0]        phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic [AMT_W-1:0]  amount_ff, amount_in;
   logic [2:0][7:0]   chars_ff, chars_in;
   logic [1:0]        len_ff, len_in;
   logic [1:0]        fault_ff, fault_in;

   logic              is_digit, is_space, is_lower;
   logic [AMT_W+3:0]  amt_ext, amt_x10;
   logic              digit_ovf;
   logic [UNIT_W-1:0] uv_now, uv_end;
   logic              term;
   logic [UNIT_W-1:0] term_unit;

   assign is_digit = (char_in >= 8'h30) && (char_in <= 8'h39);
   assign is_space = (char_in == 8'h20) || ((char_in >= 8'h09) && (char_in <= 8'h0D));
   assign is_lower = (char_in >= 8'h61) && (char_in <= 8'h7A);

   // amount * 10 + digit, the digit value is the low nibble
   assign amt_ext   = {4'b0, amount_ff};
   assign amt_x10   = (amt_ext << 3) + (amt_ext << 1) + {{(AMT_W){1'b0}}, char_in[3:0]};
   assign digit_ovf = |amt_x10[AMT_W+3:AMT_W];

   assign uv_now = unit_value(chars_ff, len_ff);

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      amount_in = amount_ff;
      chars_in  = chars_ff;
      len_in    = len_ff;
      fault_in  = fault_ff;
      term      = 1'b0;
      term_unit = uv_now;
      uv_end    = '0;

      if (fault_ff == ST_OK) begin
         unique case (phase_ff)
            PH_SIGN, PH_DONE: begin
               if (is_digit) begin
                  if (digit_ovf) fault_in = ST_OVERFLOW;
                  else amount_in = amt_x10[AMT_W-1:0];
                  phase_in = PH_DIGITS;
               end else if (!is_space) begin
                  fault_in = ST_MALFORMED;
               end
            end
            PH_DIGITS: begin
               if (is_digit) begin
                  if (digit_ovf) fault_in = ST_OVERFLOW;
                  else amount_in = amt_x10[AMT_W-1:0];
               end else if (is_space) begin
                  phase_in = PH_GAP;
               end else if (is_lower) begin
                  chars_in[0] = char_in;
                  len_in      = 2'd1;
                  phase_in    = PH_UNIT;
               end else begin
                  fault_in = ST_UNIT;
               end
            end
            PH_GAP: begin
               if (is_lower) begin
                  chars_in[0] = char_in;
                  len_in      = 2'd1;
                  phase_in    = PH_UNIT;
               end else if (!is_space) begin
                  fault_in = ST_UNIT;
               end
            end
            PH_UNIT: begin
               if (is_lower) begin
                  if (len_ff == 2'd3) begin
                     fault_in = ST_UNIT;
                  end else begin
                     chars_in[len_ff] = char_in;
                     len_in           = len_ff + 2'd1;
                  end
               end else begin
                  // the term closes here, its product is formed downstream
                  amount_in = '0;
                  len_in    = 2'd0;
                  if (uv_now == '0) begin
                     fault_in = ST_UNIT;
                  end else begin
                     term = 1'b1;
                     if (is_space) begin
                        phase_in = PH_DONE;
                     end else if (is_digit) begin
                        amount_in = {{(AMT_W-4){1'b0}}, char_in[3:0]};
                        phase_in  = PH_DIGITS;
                     end else begin
                        fault_in = ST_MALFORMED;
                     end
                  end
               end
            end
            default: begin
               if (char_in == CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = PH_SIGN;
               end else if (is_digit) begin
                  if (digit_ovf) fault_in = ST_OVERFLOW;
                  else amount_in = amt_x10[AMT_W-1:0];
                  phase_in = PH_DIGITS;
               end else if (!is_space) begin
                  fault_in = ST_MALFORMED;
               end
            end
         endcase
      end

      // end of text
      if (last && fault_in == ST_OK) begin
         uv_end = unit_value(chars_in, len_in);
         unique case (phase_in)
            PH_UNIT: begin
               if (uv_end == '0) begin
                  fault_in = ST_UNIT;
               end else begin
                  term      = 1'b1;
                  term_unit = uv_end;
               end
            end
            PH_DIGITS, PH_GAP: fault_in = ST_UNIT;
            PH_DONE:           fault_in = ST_OK;
            default:           fault_in = ST_MALFORMED;
         endcase
      end
   end

   // a term closing mid-text uses the amount held before this byte
   assign amount_o    = amount_ff;
   assign unit_o      = term_unit;
   assign tok_o.term  = term;
   assign tok_o.last  = last;
   assign tok_o.neg   = neg_in;
   assign tok_o.fault = fault_in;

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff  <= PH_LEAD;
         neg_ff    <= 1'b0;
         amount_ff <= '0;
         chars_ff  <= '0;
         len_ff    <= 2'd0;
         fault_ff  <= ST_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         neg_ff    <= neg_in;
         amount_ff <= amount_in;
         chars_ff  <= chars_in;
         len_ff    <= len_in;
         fault_ff  <= fault_in;
      end
   end

endmodule

@@ rtl/dsp_mul.sv @@
// ----------------------------------------------------------------------------
// dsp_mul
// two-stage amount times unit multiplier with overflow flag
// ----------------------------------------------------------------------------
module dsp_mul import dsp_pkg::*; (
   input  logic              clock,
   input  logic              en_pp,
   input  logic              en_sum,
   input  logic [AMT_W-1:0]  amount,
   input  logic [UNIT_W-1:0] unit,
   output logic [AMT_W-1:0]  product,
   output logic              product_ovf
);

   logic [63:0]       pp0_ff;   // amount[31:0]  x unit[31:0]
   logic [62:0]       pp1_ff;   // amount[62:32] x unit[31:0]
   logic [34:0]       pp2_ff;   // amount[31:0]  x unit[34:32]
   logic [33:0]       pp3_ff;   // amount[62:32] x unit[34:32]
   logic [PROD_W-1:0] sum;
   logic [AMT_W-1:0]  product_ff;
   logic              ovf_ff;

   always_ff @(posedge clock) begin
      if (en_pp) begin
         pp0_ff <= amount[31:0]  * unit[31:0];
         pp1_ff <= amount[62:32] * unit[31:0];
         pp2_ff <= amount[31:0]  * unit[34:32];
         pp3_ff <= amount[62:32] * unit[34:32];
      end
   end

   assign sum = {34'b0, pp0_ff}
              + {3'b0, pp1_ff, 32'b0}
              + {31'b0, pp2_ff, 32'b0}
              + {pp3_ff, 64'b0};

   always_ff @(posedge clock) begin
      if (en_sum) begin
         product_ff <= sum[AMT_W-1:0];
         ovf_ff     <= |sum[PROD_W-1:AMT_W];
      end
   end

   assign product     = product_ff;
   assign product_ovf = ovf_ff;

endmodule

@@ rtl/duration_string_parser.sv @@
// ----------------------------------------------------------------------------
// duration_string_parser
// streaming duration text to signed millisecond total
// ----------------------------------------------------------------------------
// usage
//   req_* carries the text one byte per transaction, req_last on the final
//   byte. each text gives exactly one rsp_* transaction: the signed total in
//   milliseconds and a status (ok, malformed, unknown unit, overflow); the
//   total reads zero whenever status is not ok
//   throughput is one byte per cycle while req_stall is low; back-to-back texts need no gap
//   the result is registered once the final byte has passed the stages
//   input register, parse, partial products, product sum and accumulate
//   into the result register
//   the parser handles bytes at full rate unless stalled; each finished term
//   rides down a two-stage split multiplier and is summed in the accumulate stage
//   while rsp_stall is high a waiting result holds; bytes keep flowing in
//   until a second final byte reaches the accumulate stage, then req_stall
//   backs up stage by stage
//   synchronous reset empties every stage and returns the parser to the
//   leading white space state with no sign, amount, total or error
// ----------------------------------------------------------------------------
module duration_string_parser import dsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_in,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_duration_ms,
   output logic [1:0]         rsp_status
);

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ready1, ready2, ready3, ready4;
   logic fire1, fire4;
   logic out_free;

   // stage 1: raw byte
   logic [7:0]        char1_ff;
   logic              last1_ff;

   // stage 2: parsed token plus term operands
   token_type         tok_in, tok2_ff, tok3_ff, tok4_ff;
   logic [AMT_W-1:0]  amount_in, amount2_ff;
   logic [UNIT_W-1:0] unit_in, unit2_ff;

   // product from the multiplier, aligned with stage 4
   logic [AMT_W-1:0]  prod4;
   logic              prod4_ovf;

   // running sum for the current text
   logic [AMT_W-1:0]  total_ff, total_in;
   logic              aovf_ff, aovf_in;
   logic [AMT_W:0]    sum;
   logic              add_ok, term_ovf;

   // result
   logic              rsp_valid_ff;
   logic [63:0]       rsp_dur_ff, dur_in;
   logic [1:0]        rsp_status_ff, status_in;

   // ready runs back from the result register; only a final-byte token
   // can be held, everything else drains freely
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire4    = v4_ff && (!tok4_ff.last || out_free);
   assign ready4   = !v4_ff || fire4;
   assign ready3   = !v3_ff || ready4;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign fire1    = v1_ff && ready2;
   assign req_stall = !ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         char1_ff <= req_char_in;
         last1_ff <= req_last;
      end
      if (ready2) begin
         tok2_ff    <= tok_in;
         amount2_ff <= amount_in;
         unit2_ff   <= unit_in;
      end
      if (ready3) tok3_ff <= tok2_ff;
      if (ready4) tok4_ff <= tok3_ff;
   end

   // parser state moves only when its byte moves on
   dsp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (fire1),
      .char_in  (char1_ff),
      .last     (last1_ff),
      .tok_o    (tok_in),
      .amount_o (amount_in),
      .unit_o   (unit_in)
   );

   dsp_mul u_mul (
      .clock       (clock),
      .en_pp       (ready3),
      .en_sum      (ready4),
      .amount      (amount2_ff),
      .unit        (unit2_ff),
      .product     (prod4),
      .product_ovf (prod4_ovf)
   );

   // accumulate; after the first overflow later terms are dropped
   assign add_ok   = tok4_ff.term && !aovf_ff;
   assign sum      = {1'b0, total_ff} + {1'b0, prod4};
   assign term_ovf = prod4_ovf || sum[AMT_W];
   assign aovf_in  = aovf_ff || (add_ok && term_ovf);
   assign total_in = (add_ok && !term_ovf) ? sum[AMT_W-1:0] : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         aovf_ff  <= 1'b0;
      end else if (fire4) begin
         if (tok4_ff.last) begin
            total_ff <= '0;
            aovf_ff  <= 1'b0;
         end else begin
            total_ff <= total_in;
            aovf_ff  <= aovf_in;
         end
      end
   end

   // a term overflow always comes from a term closed before any later parse
   // error, so it takes precedence
   always_comb begin
      status_in = aovf_in ? ST_OVERFLOW : tok4_ff.fault;
      if (status_in != ST_OK) dur_in = '0;
      else if (tok4_ff.neg)   dur_in = 64'(0) - {1'b0, total_in};
      else                    dur_in = {1'b0, total_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= v4_ff && tok4_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && v4_ff && tok4_ff.last) begin
         rsp_dur_ff    <= dur_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_duration_ms = rsp_dur_ff;
   assign rsp_status      = rsp_status_ff;

   // an error result never carries a total
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_duration_ms == 64'sd0))
      else $error("error result with non-zero duration");

   // the overflow mark lasts until its text ends
   a_aovf_sticky: assert property (@(posedge clock) disable iff (reset)
      (aovf_ff && !(fire4 && tok4_ff.last)) |=> aovf_ff)
      else $error("accumulate overflow cleared mid text");

   // a final token blocked by a waiting result stays in the accumulate stage
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && tok4_ff.last && rsp_valid && rsp_stall) |=> (v4_ff && tok4_ff.last))
      else $error("final token lost while result stalled");

endmodule

@@ tb/duration_string_parser_tb.sv @@
// ----------------------------------------------------------------------------
// duration_string_parser_tb
// self-checking bench for the streaming duration text parser
// ----------------------------------------------------------------------------
// texts fed one byte per transaction, final byte marked
// byte-level model of the parser predicts total and status of each text
// checker compares every result transaction with the oldest prediction
// directed texts: each unit, the sign, white space, error kinds, 63-bit limits
// random texts: mostly well formed, some corrupted or cut short, some noise,
// under three mixes of sender and receiver idling
// ----------------------------------------------------------------------------
module duration_string_parser_tb import dsp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] MAX_MAG        = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no transaction
   localparam int          SETTLE_CYCLES  = 16;    // idle wait before the verdict
   localparam int          RANDOM_BYTES   = 480;   // per idling mix

   // where the byte-level model stands within a text
   typedef enum logic [2:0] {
      LEADING, AFTER_SIGN, AFTER_TERM, IN_DIGITS, IN_GAP, IN_UNIT
   } parse_phase_type;

   typedef struct packed {
      logic [63:0] ms;
      logic [1:0]  status;
   } duration_result_type;

   // dut ports, inputs all known from time zero
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_in = 8'h00;
   logic               req_last    = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic signed [63:0] rsp_duration_ms;
   logic [1:0]         rsp_status;

   // model state: mirrors the parser between bytes
   parse_phase_type p_phase;
   logic            p_neg;
   logic [63:0]     p_amount;
   logic [63:0]     p_total;
   logic [7:0]      p_unit [3];
   int              p_unit_len;
   logic [1:0]      p_fault;

   // predicted totals waiting for their result transaction, oldest first
   duration_result_type awaited_results [$];
   duration_result_type head;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int failures      = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;
   int status_count [4] = '{0, 0, 0, 0};

   duration_string_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_duration_ms (rsp_duration_ms),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // byte-level model of the parser
   // ------------------------------------------------------------------------

   // white space is space plus tab through carriage return
   function automatic bit is_space(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_lower(input logic [7:0] c);
      return c >= "a" && c <= "z";
   endfunction

   function automatic void clear_parser();
      p_phase    = LEADING;
      p_neg      = 1'b0;
      p_amount   = '0;
      p_total    = '0;
      p_unit     = '{8'h00, 8'h00, 8'h00};
      p_unit_len = 0;
      p_fault    = ST_OK;
   endfunction

   // only the first error of a text is kept
   function automatic void note_fault(input logic [1:0] f);
      if (p_fault == ST_OK) begin
         p_fault = f;
      end
   endfunction

   // milliseconds per unit, zero when the letters name no unit
   function automatic logic [63:0] unit_ms();
      if (p_unit_len == 1) begin
         case (p_unit[0])
            "y":     return 64'd31556952000;
            "w":     return 64'd604800000;
            "d":     return 64'd86400000;
            "h":     return 64'd3600000;
            "m":     return 64'd60000;
            "s":     return 64'd1000;
            default: return 64'd0;
         endcase
      end
      if (p_unit_len == 2 && p_unit[0] == "m" && p_unit[1] == "s") begin
         return 64'd1;
      end
      if (p_unit_len == 3 && {p_unit[0], p_unit[1], p_unit[2]} == "mon") begin
         return 64'd2629746000;
      end
      return 64'd0;
   endfunction

   // append a digit unless the amount would pass the 63-bit magnitude
   function automatic void take_digit(input logic [7:0] c);
      logic [63:0] d;
      d = {56'd0, c - 8'h30};
      if (p_amount > (MAX_MAG - d) / 10) begin
         note_fault(ST_OVERFLOW);
      end else begin
         p_amount = p_amount * 10 + d;
      end
      p_phase = IN_DIGITS;
   endfunction

   function automatic void open_unit(input logic [7:0] c);
      p_unit[0]  = c;
      p_unit_len = 1;
      p_phase    = IN_UNIT;
   endfunction

   // add amount times unit to the total, checking the product first
   function automatic void close_term();
      logic [63:0] v;
      v = unit_ms();
      if (v == 0) begin
         note_fault(ST_UNIT);
      end else if (p_amount > (MAX_MAG - p_total) / v) begin
         note_fault(ST_OVERFLOW);
      end else begin
         p_total = p_total + p_amount * v;
      end
      p_amount   = '0;
      p_unit_len = 0;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      if (p_fault != ST_OK) begin
         return;
      end
      case (p_phase)
         AFTER_SIGN, AFTER_TERM: begin
            if (is_digit(c)) take_digit(c);
            else if (!is_space(c)) note_fault(ST_MALFORMED);
         end
         IN_DIGITS: begin
            if (is_digit(c)) take_digit(c);
            else if (is_space(c)) p_phase = IN_GAP;
            else if (is_lower(c)) open_unit(c);
            else note_fault(ST_UNIT);
         end
         IN_GAP: begin
            if (is_lower(c)) open_unit(c);
            else if (!is_space(c)) note_fault(ST_UNIT);
         end
         IN_UNIT: begin
            if (is_lower(c)) begin
               // a fourth letter can never name a unit
               if (p_unit_len >= 3) begin
                  note_fault(ST_UNIT);
               end else begin
                  p_unit[p_unit_len] = c;
                  p_unit_len++;
               end
            end else begin
               close_term();
               if (p_fault == ST_OK) begin
                  if (is_space(c)) p_phase = AFTER_TERM;
                  else if (is_digit(c)) take_digit(c);
                  else note_fault(ST_MALFORMED);
               end
            end
         end
         default: begin
            // leading white space, the sign or the first digit
            if (c == "-") begin
               p_neg   = 1'b1;
               p_phase = AFTER_SIGN;
            end else if (is_digit(c)) begin
               take_digit(c);
            end else if (!is_space(c)) begin
               note_fault(ST_MALFORMED);
            end
         end
      endcase
   endfunction

   // feed one accepted byte; on the final byte queue the predicted result
   function automatic void predict_byte(input logic [7:0] c, input logic fin);
      duration_result_type r;
      parse_char(c);
      if (!fin) begin
         return;
      end
      if (p_fault == ST_OK) begin
         if (p_phase == IN_UNIT) close_term();
         else if (p_phase == IN_DIGITS || p_phase == IN_GAP) note_fault(ST_UNIT);
         else if (p_phase != AFTER_TERM) note_fault(ST_MALFORMED);
      end
      r.status = p_fault;
      r.ms     = (p_fault != ST_OK) ? 64'd0 : (p_neg ? -p_total : p_total);
      awaited_results.insert(awaited_results.size(), r);
      status_count[p_fault]++;
      clear_parser();
   endfunction

   // ------------------------------------------------------------------------
   // result checker and receiver stalls
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t unexpected result: expected none, got duration %0d status %0d",
                        $time, rsp_duration_ms, rsp_status);
               failures++;
            end else begin
               head = awaited_results.pop_front();
               if (rsp_duration_ms !== head.ms) begin
                  $display("%0t duration mismatch: expected %0d, got %0d",
                           $time, $signed(head.ms), rsp_duration_ms);
                  failures++;
               end
               if (rsp_status !== head.status) begin
                  $display("%0t status mismatch: expected %0d, got %0d",
                           $time, head.status, rsp_status);
                  failures++;
               end
            end
         end
         // stall decided afresh every cycle so gaps land on any pipeline stage
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: any transaction on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // one byte transaction; called at a rising edge, returns at the edge that
   // accepts it with valid still high, so the next byte may follow at once
   task automatic send_byte(input logic [7:0] c, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_last    <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_byte(c, fin);
      bytes_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic send_text(input logic [7:0] txt [$]);
      foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
   endtask

   // drop valid and hold off until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_space();
      int k;
      k = $urandom_range(9);
      return (k < 5) ? 8'h09 + k[7:0] : 8'h20;
   endfunction

   // every unit, terms back to back and with gaps, sign and all white space
   task automatic test_valid_terms();
      send_str("1y");
      send_str("2mon");
      send_str("3w 4d");
      send_str("5h6m7s8ms");
      send_str(" -  9 ms ");
      send_str("0ms");
      // tab, line feed, vertical tab, form feed and carriage return
      for (int w = 9; w <= 13; w++) send_byte(w[7:0], 1'b0);
      send_byte("7", 1'b0);
      send_byte(8'h0B, 1'b0);
      send_byte("s", 1'b0);
      send_byte(8'h0D, 1'b0);
      send_byte(" ", 1'b1);
   endtask

   // blank text, bare sign, second sign, junk where a term should start
   task automatic test_malformed_text();
      send_str(" ");
      send_str("-");
      send_str("--5s");
      send_str("x5q");
      send_str("5s,");
      send_byte(8'h00, 1'b1);
   endtask

   // empty unit, unknown letters, too many letters, bad byte after digits
   task automatic test_unit_errors();
      send_str("12");
      send_str("12 ");
      send_str("3q");
      send_str("1mons");
      send_str("5S");
      send_str("5,");
      send_str("5 ,");
      send_byte("4", 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // largest magnitude both signs, then amount, product and sum overflow
   task automatic test_overflow();
      send_str("9223372036854775807ms");
      send_str("-9223372036854775807ms");
      send_str("9223372036854775808ms");
      send_str("300000000y");
      send_str("9223372036854775807ms1ms");
   endtask

   // mostly well formed texts with random content; some corrupted or cut
   // short, some pure noise bytes
   task automatic send_random_text();
      logic [7:0] txt [$];
      string      unit_names [8];
      string      u;
      int         kind;
      int         n_dig;
      int         n;
      unit_names = '{"y", "mon", "w", "d", "h", "m", "s", "ms"};
      kind = $urandom_range(99);
      if (kind < 10) begin
         repeat ($urandom_range(1, 6)) txt.insert(txt.size(), 8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 2)) txt.insert(txt.size(), pick_space());
         if ($urandom_range(2) == 0) begin
            txt.insert(txt.size(), 8'h2D);
            repeat ($urandom_range(0, 1)) txt.insert(txt.size(), pick_space());
         end
         for (int t = $urandom_range(1, 3); t > 0; t--) begin
            // amounts mostly short, now and then near the 63-bit limit
            n = $urandom_range(99);
            n_dig = (n < 70) ? $urandom_range(1, 3) :
                    (n < 90) ? $urandom_range(4, 9) : $urandom_range(15, 20);
            repeat (n_dig) txt.insert(txt.size(), 8'(8'h30 + $urandom_range(9)));
            repeat ($urandom_range(0, 1)) txt.insert(txt.size(), pick_space());
            u = unit_names[$urandom_range(7)];
            for (int i = 0; i < u.len(); i++) txt.insert(txt.size(), u[i]);
            repeat ($urandom_range(0, 1)) txt.insert(txt.size(), pick_space());
         end
         if (kind < 30) begin
            if ($urandom_range(1) == 1) begin
               txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
            end else begin
               n   = $urandom_range(1, txt.size());
               txt = txt[0:n-1];
            end
         end
      end
      send_text(txt);
   endtask

   task automatic test_random_texts(input int send_pct, input int recv_pct);
      int stop_at;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < stop_at) send_random_text();
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      clear_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed texts run under the first idling mix
      send_idle_pct = 9;
      recv_idle_pct = 56;
      test_valid_terms();
      test_malformed_text();
      test_unit_errors();
      test_overflow();

      test_random_texts(9, 56);
      wait_for_results();          // sender holds off until the pipe is empty
      test_random_texts(56, 9);
      wait_for_results();
      test_random_texts(0, 0);
      wait_for_results();

      // let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0) begin
         $display("%0t %0d predicted results never arrived", $time, awaited_results.size());
         failures++;
      end

      $display("sent %0d bytes; texts: %0d ok, %0d malformed, %0d unknown unit, %0d overflow",
               bytes_sent, status_count[ST_OK], status_count[ST_MALFORMED],
               status_count[ST_UNIT], status_count[ST_OVERFLOW]);
      $display("idling mixes: sender 9%% / receiver 56%%, 56%% / 9%%, none; %0d failures",
               failures);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
